// ----- rtl/lav_pkg.sv -----
// ----------------------------------------------------------------------------
// lav_pkg: shared types and constants of the look-at view matrix block
// Item structs of both directions, axis format and the normalizer latency.
// ----------------------------------------------------------------------------
package lav_pkg;

	// Axis components are Q2.30.
	localparam int AXIS_FRAC = 30;
	localparam int AXIS_W    = 32;
	localparam int COORD_W   = 32;
	localparam int SHIFT_W   = 48;

	// Normalizer: abs, max, msb, shift, square, sum, 32 root bits,
	// dividend set-up, 31 quotient bits, sign.
	localparam int ROOT_BITS = 32;
	localparam int QUOT_BITS = AXIS_FRAC + 1;
	localparam int NORM_LAT  = 6 + ROOT_BITS + 1 + QUOT_BITS + 1;

	typedef struct packed {
		logic signed [COORD_W-1:0] eye_x;
		logic signed [COORD_W-1:0] eye_y;
		logic signed [COORD_W-1:0] eye_z;
		logic signed [COORD_W-1:0] look_x;
		logic signed [COORD_W-1:0] look_y;
		logic signed [COORD_W-1:0] look_z;
		logic signed [COORD_W-1:0] upward_x;
		logic signed [COORD_W-1:0] upward_y;
		logic signed [COORD_W-1:0] upward_z;
	} setup_t;

	typedef struct packed {
		logic signed [AXIS_W-1:0]  right_x;
		logic signed [AXIS_W-1:0]  right_y;
		logic signed [AXIS_W-1:0]  right_z;
		logic signed [AXIS_W-1:0]  above_x;
		logic signed [AXIS_W-1:0]  above_y;
		logic signed [AXIS_W-1:0]  above_z;
		logic signed [AXIS_W-1:0]  back_x;
		logic signed [AXIS_W-1:0]  back_y;
		logic signed [AXIS_W-1:0]  back_z;
		logic signed [SHIFT_W-1:0] shift_x;
		logic signed [SHIFT_W-1:0] shift_y;
		logic signed [SHIFT_W-1:0] shift_z;
	} result_t;

endpackage

// ----- rtl/lav_norm.sv -----
// ----------------------------------------------------------------------------
// lav_norm: pipelined 3-vector normalizer
// Scales the vector into [2^30, 2^31), takes a bit-per-stage square root of
// the squared length and divides each component one quotient bit per stage.
// One vector per cycle, zero vector gives zero.
// ----------------------------------------------------------------------------
module lav_norm import lav_pkg::*; #(
	parameter int IN_W = 64
) (
	input  logic                     clk,
	input  logic signed [IN_W-1:0]   vec  [3],
	output logic signed [AXIS_W-1:0] unit [3]
);

	localparam int PW = $clog2(IN_W);
	localparam int AW = AXIS_FRAC + 1;

	logic [IN_W-1:0] mag_s1 [3];
	logic [2:0]      neg_s1;
	logic [IN_W-1:0] mag_s2 [3];
	logic [IN_W-1:0] m_s2;
	logic [2:0]      neg_s2;
	logic [IN_W-1:0] mag_s3 [3];
	logic [PW-1:0]   p_s3;
	logic            zero_s3;
	logic [2:0]      neg_s3;
	logic [AW-1:0]   a_s4 [3];
	logic [2:0]      neg_s4;
	logic            zero_s4;
	logic [2*AW-1:0] sq_s5 [3];
	logic [AW-1:0]   a_s5 [3];
	logic [2:0]      neg_s5;
	logic            zero_s5;

	// root stages: index 0 is the sum register
	logic [63:0]     rt_rem  [0:ROOT_BITS];
	logic [31:0]     rt_root [0:ROOT_BITS];
	logic [AW-1:0]   rt_a    [0:ROOT_BITS][3];
	logic [2:0]      rt_neg  [0:ROOT_BITS];
	logic            rt_zero [0:ROOT_BITS];
	logic [63:0]     rt_rem_n  [ROOT_BITS];
	logic [31:0]     rt_root_n [ROOT_BITS];

	// divide stages: index 0 is the dividend set-up register
	logic [2*AW-1:0] dv_num  [0:QUOT_BITS][3];
	logic [31:0]     dv_rem  [0:QUOT_BITS][3];
	logic [AW-1:0]   dv_q    [0:QUOT_BITS][3];
	logic [31:0]     dv_den  [0:QUOT_BITS];
	logic [2:0]      dv_neg  [0:QUOT_BITS];
	logic            dv_zero [0:QUOT_BITS];
	logic [31:0]     dv_rem_n [QUOT_BITS][3];
	logic            dv_bit_n [QUOT_BITS][3];

	logic [IN_W-1:0] m_c;
	logic [PW-1:0]   p_c;
	logic [AW-1:0]   a_c [3];

	always_comb begin
		m_c = mag_s1[0];
		if (mag_s1[1] > m_c) m_c = mag_s1[1];
		if (mag_s1[2] > m_c) m_c = mag_s1[2];
	end

	// msb of the largest magnitude
	always_comb begin
		p_c = '0;
		for (int b = 0; b < IN_W; b++) begin
			if (m_s2[b]) p_c = PW'(b);
		end
	end

	always_comb begin
		logic [IN_W-1:0] t;
		for (int i = 0; i < 3; i++) begin
			if (p_s3 > PW'(AXIS_FRAC)) t = mag_s3[i] >> (p_s3 - PW'(AXIS_FRAC));
			else t = mag_s3[i] << (PW'(AXIS_FRAC) - p_s3);
			a_c[i] = t[AW-1:0];
		end
	end

	// one root bit per stage: keep n - r^2, try r + 2^b
	always_comb begin
		logic [65:0] trial;
		for (int k = 0; k < ROOT_BITS; k++) begin
			trial = ({34'd0, rt_root[k]} << (ROOT_BITS - k))
				+ (66'd1 << (2 * (ROOT_BITS - 1 - k)));
			if ({2'b00, rt_rem[k]} >= trial) begin
				rt_rem_n[k]  = rt_rem[k] - trial[63:0];
				rt_root_n[k] = rt_root[k] | (32'd1 << (ROOT_BITS - 1 - k));
			end else begin
				rt_rem_n[k]  = rt_rem[k];
				rt_root_n[k] = rt_root[k];
			end
		end
	end

	// one quotient bit per stage
	always_comb begin
		logic [32:0] r2;
		for (int k = 0; k < QUOT_BITS; k++) begin
			for (int i = 0; i < 3; i++) begin
				r2 = {dv_rem[k][i], dv_num[k][i][QUOT_BITS - 1 - k]};
				dv_bit_n[k][i] = r2 >= {1'b0, dv_den[k]};
				dv_rem_n[k][i] = dv_bit_n[k][i] ? 32'(r2 - {1'b0, dv_den[k]})
					: r2[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			neg_s1[i] <= vec[i][IN_W-1];
			mag_s1[i] <= vec[i][IN_W-1] ? (~vec[i] + 1'b1) : vec[i];
		end
		mag_s2  <= mag_s1;
		m_s2    <= m_c;
		neg_s2  <= neg_s1;
		mag_s3  <= mag_s2;
		p_s3    <= p_c;
		zero_s3 <= (m_s2 == '0);
		neg_s3  <= neg_s2;
		a_s4    <= a_c;
		neg_s4  <= neg_s3;
		zero_s4 <= zero_s3;
		for (int i = 0; i < 3; i++) sq_s5[i] <= a_s4[i] * a_s4[i];
		a_s5    <= a_s4;
		neg_s5  <= neg_s4;
		zero_s5 <= zero_s4;

		rt_rem[0]  <= 64'(sq_s5[0]) + 64'(sq_s5[1]) + 64'(sq_s5[2]);
		rt_root[0] <= '0;
		rt_a[0]    <= a_s5;
		rt_neg[0]  <= neg_s5;
		rt_zero[0] <= zero_s5;
		for (int k = 0; k < ROOT_BITS; k++) begin
			rt_rem[k+1]  <= rt_rem_n[k];
			rt_root[k+1] <= rt_root_n[k];
			rt_a[k+1]    <= rt_a[k];
			rt_neg[k+1]  <= rt_neg[k];
			rt_zero[k+1] <= rt_zero[k];
		end

		// dividend: a * 2^30 + s / 2, rounds the quotient half up
		for (int i = 0; i < 3; i++) begin
			dv_num[0][i] <= {rt_a[ROOT_BITS][i], AXIS_FRAC'(0)}
				+ (2*AW)'(rt_root[ROOT_BITS] >> 1);
			dv_rem[0][i] <= 32'(({rt_a[ROOT_BITS][i], AXIS_FRAC'(0)}
				+ (2*AW)'(rt_root[ROOT_BITS] >> 1)) >> QUOT_BITS);
			dv_q[0][i]   <= '0;
		end
		dv_den[0]  <= rt_root[ROOT_BITS];
		dv_neg[0]  <= rt_neg[ROOT_BITS];
		dv_zero[0] <= rt_zero[ROOT_BITS];
		for (int k = 0; k < QUOT_BITS; k++) begin
			for (int i = 0; i < 3; i++) begin
				dv_num[k+1][i] <= dv_num[k][i];
				dv_rem[k+1][i] <= dv_rem_n[k][i];
				dv_q[k+1][i]   <= {dv_q[k][i][AW-2:0], dv_bit_n[k][i]};
			end
			dv_den[k+1]  <= dv_den[k];
			dv_neg[k+1]  <= dv_neg[k];
			dv_zero[k+1] <= dv_zero[k];
		end

		for (int i = 0; i < 3; i++) begin
			logic [AW-1:0] qc;
			qc = (dv_q[QUOT_BITS][i] > (AW'(1) << AXIS_FRAC)) ? (AW'(1) << AXIS_FRAC)
				: dv_q[QUOT_BITS][i];
			if (dv_zero[QUOT_BITS]) unit[i] <= '0;
			else if (dv_neg[QUOT_BITS][i]) unit[i] <= -$signed(AXIS_W'(qc));
			else unit[i] <= $signed(AXIS_W'(qc));
		end
	end

endmodule

// ----- rtl/look_at_view_matrix_top.sv -----
// ----------------------------------------------------------------------------
// look_at_view_matrix_top: fixed-point look-at view matrix
// Builds the camera axes and translation terms from eye, target and up.
// ----------------------------------------------------------------------------
// Usage: pulse start with a setup item; busy is always low, so one item may
// enter every cycle. Each item comes back on result with done high for
// exactly one cycle, in order. The receiver cannot stall. Latency is set by
// three normalizers in series, each a square root of one bit per stage
// followed by a divide of one quotient bit per stage. A zero-length vector
// normalizes to zero, so an up vector parallel to the view direction yields
// zero right and above axes.
// ----------------------------------------------------------------------------
module look_at_view_matrix_top import lav_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  setup_t  setup,
	output logic    done,
	output result_t result
);

	localparam int L     = NORM_LAT;
	localparam int TOTAL = 9 + 3 * L;

	logic [TOTAL-1:0] vld_q;

	logic signed [32:0]       d_s1 [3];
	logic signed [31:0]       eye_s1 [3];
	logic signed [31:0]       up_s1 [3];
	logic signed [31:0]       eye_d [0:3*L+3][3];
	logic signed [31:0]       up_d  [0:L-1][3];
	logic signed [AXIS_W-1:0] zb [3];
	logic signed [AXIS_W-1:0] xr [3];
	logic signed [AXIS_W-1:0] ya [3];
	logic signed [AXIS_W-1:0] zb_d [0:2*L+7][3];
	logic signed [AXIS_W-1:0] xr_d [0:L+5][3];
	logic signed [AXIS_W-1:0] ya_d [0:3][3];
	logic signed [63:0]       c1p_s [6];
	logic signed [63:0]       c1_s [3];
	logic signed [63:0]       c2p_s [6];
	logic signed [63:0]       c2_s [3];
	logic signed [63:0]       dp_s [3][3];
	logic signed [63:0]       dot_s [3];
	logic [63:0]              mag_s [3];
	logic [2:0]               pos_s;
	logic signed [SHIFT_W-1:0] sh_s [3];

	// the pipeline never stalls
	assign busy = 1'b0;

	// advance valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[TOTAL-2:0], start};
		end
	end

	// take the item, form eye - look exactly
	always_ff @(posedge clk) begin
		d_s1[0]   <= 33'(setup.eye_x) - 33'(setup.look_x);
		d_s1[1]   <= 33'(setup.eye_y) - 33'(setup.look_y);
		d_s1[2]   <= 33'(setup.eye_z) - 33'(setup.look_z);
		eye_s1[0] <= setup.eye_x;
		eye_s1[1] <= setup.eye_y;
		eye_s1[2] <= setup.eye_z;
		up_s1[0]  <= setup.upward_x;
		up_s1[1]  <= setup.upward_y;
		up_s1[2]  <= setup.upward_z;
	end

	// hold eye, up and the axes until their consumers reach them
	always_ff @(posedge clk) begin
		eye_d[0] <= eye_s1;
		for (int k = 1; k <= 3*L+3; k++) eye_d[k] <= eye_d[k-1];
		up_d[0] <= up_s1;
		for (int k = 1; k < L; k++) up_d[k] <= up_d[k-1];
		zb_d[0] <= zb;
		for (int k = 1; k <= 2*L+7; k++) zb_d[k] <= zb_d[k-1];
		xr_d[0] <= xr;
		for (int k = 1; k <= L+5; k++) xr_d[k] <= xr_d[k-1];
		ya_d[0] <= ya;
		for (int k = 1; k <= 3; k++) ya_d[k] <= ya_d[k-1];
	end

	// back axis
	lav_norm #(.IN_W(33)) u_norm_back (
		.clk  (clk),
		.vec  (d_s1),
		.unit (zb)
	);

	// up x back: register the products, then the differences
	always_ff @(posedge clk) begin
		c1p_s[0] <= up_d[L-1][1] * zb[2];
		c1p_s[1] <= up_d[L-1][2] * zb[1];
		c1p_s[2] <= up_d[L-1][2] * zb[0];
		c1p_s[3] <= up_d[L-1][0] * zb[2];
		c1p_s[4] <= up_d[L-1][0] * zb[1];
		c1p_s[5] <= up_d[L-1][1] * zb[0];
		c1_s[0]  <= c1p_s[0] - c1p_s[1];
		c1_s[1]  <= c1p_s[2] - c1p_s[3];
		c1_s[2]  <= c1p_s[4] - c1p_s[5];
	end

	// right axis
	lav_norm #(.IN_W(64)) u_norm_right (
		.clk  (clk),
		.vec  (c1_s),
		.unit (xr)
	);

	// back x right
	always_ff @(posedge clk) begin
		c2p_s[0] <= zb_d[L+1][1] * xr[2];
		c2p_s[1] <= zb_d[L+1][2] * xr[1];
		c2p_s[2] <= zb_d[L+1][2] * xr[0];
		c2p_s[3] <= zb_d[L+1][0] * xr[2];
		c2p_s[4] <= zb_d[L+1][0] * xr[1];
		c2p_s[5] <= zb_d[L+1][1] * xr[0];
		c2_s[0]  <= c2p_s[0] - c2p_s[1];
		c2_s[1]  <= c2p_s[2] - c2p_s[3];
		c2_s[2]  <= c2p_s[4] - c2p_s[5];
	end

	// above axis
	lav_norm #(.IN_W(64)) u_norm_above (
		.clk  (clk),
		.vec  (c2_s),
		.unit (ya)
	);

	// translation: exact dot with the eye, negate, round half away from zero
	// to the coordinate scale, clamp to 48 bits
	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			dp_s[0][j] <= xr_d[L+1][j] * eye_d[3*L+3][j];
			dp_s[1][j] <= ya[j] * eye_d[3*L+3][j];
			dp_s[2][j] <= zb_d[2*L+3][j] * eye_d[3*L+3][j];
		end
		for (int a = 0; a < 3; a++) begin
			logic [63:0] q;
			dot_s[a] <= dp_s[a][0] + dp_s[a][1] + dp_s[a][2];
			pos_s[a] <= dot_s[a] > 0;
			mag_s[a] <= (dot_s[a] > 0) ? dot_s[a] : -dot_s[a];
			q = (mag_s[a] + (64'd1 << (AXIS_FRAC - 1))) >> AXIS_FRAC;
			if (pos_s[a]) begin
				if (q > (64'd1 << (SHIFT_W - 1))) q = 64'd1 << (SHIFT_W - 1);
				sh_s[a] <= SHIFT_W'(-q);
			end else begin
				if (q > (64'd1 << (SHIFT_W - 1)) - 1) q = (64'd1 << (SHIFT_W - 1)) - 1;
				sh_s[a] <= SHIFT_W'(q);
			end
		end
	end

	assign done           = vld_q[TOTAL-1];
	assign result.right_x = xr_d[L+5][0];
	assign result.right_y = xr_d[L+5][1];
	assign result.right_z = xr_d[L+5][2];
	assign result.above_x = ya_d[3][0];
	assign result.above_y = ya_d[3][1];
	assign result.above_z = ya_d[3][2];
	assign result.back_x  = zb_d[2*L+7][0];
	assign result.back_y  = zb_d[2*L+7][1];
	assign result.back_z  = zb_d[2*L+7][2];
	assign result.shift_x = sh_s[0];
	assign result.shift_y = sh_s[1];
	assign result.shift_z = sh_s[2];

endmodule
